// ----- sv/scp_pkg.sv -----
// Shared types and constants for the sector cache directory.
package scp_pkg;

  localparam int Entries    = 32;
  localparam int SectorBits = 16;
  localparam int SlotBits   = $clog2(Entries);
  localparam int CountBits  = $clog2(Entries + 1);
  localparam int WalkBits   = $clog2(2 * Entries + 1);

  typedef logic [SlotBits-1:0]   slot_t;
  typedef logic [SectorBits-1:0] sector_t;

  typedef enum logic [1:0] {
    KIND_READ     = 2'd0,
    KIND_WRITE    = 2'd1,
    KIND_PREFETCH = 2'd2,
    KIND_FLUSH    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_WALK,
    ST_ALLOC,
    ST_FLUSH,
    ST_OUT
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;        // capture request
    logic scan_clr;    // reset scan index
    logic scan_step;   // advance scan index
    logic hit_emit;    // latch hit result and update bits
    logic walk_step;   // clear used bit at hand, advance hand
    logic alloc;       // fill slot chosen, latch miss result
    logic flush_emit;  // latch flush word for current scan slot, clean it
    logic flush_none;  // latch empty flush word
    logic set_last;    // last flag for latched word
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_flush;
    logic match;       // scanned slot holds the requested sector
    logic scan_end;    // scan index at last slot
    logic full;
    logic hand_used;   // used bit set at hand
    logic walk_limit;  // walk has run two passes
    logic scan_dirty;  // scanned slot valid and dirty
    logic more_dirty;  // a dirty valid slot exists above scan index
    logic any_emitted;
  } stat_t;

endpackage

// ----- sv/scp_ctrl.sv -----
// Controller state machine for the sector cache directory.
module scp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  scp_pkg::stat_t st,
  output scp_pkg::cmd_t  cmd
);
  import scp_pkg::*;

  state_t state_r, state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load     = 1'b1;
          cmd.scan_clr = 1'b1;
          state_nxt    = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (st.is_flush) begin
          state_nxt = ST_FLUSH;
        end else if (st.match) begin
          cmd.hit_emit = 1'b1;
          cmd.set_last = 1'b1;
          state_nxt    = ST_OUT;
        end else if (st.scan_end) begin
          state_nxt = st.full ? ST_WALK : ST_ALLOC;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_WALK: begin
        if (st.hand_used && !st.walk_limit) cmd.walk_step = 1'b1;
        else state_nxt = ST_ALLOC;
      end
      ST_ALLOC: begin
        cmd.alloc    = 1'b1;
        cmd.set_last = 1'b1;
        state_nxt    = ST_OUT;
      end
      ST_FLUSH: begin
        if (st.scan_dirty) begin
          cmd.flush_emit = 1'b1;
          cmd.set_last   = !st.more_dirty;
          state_nxt      = ST_OUT;
        end else if (st.scan_end) begin
          if (!st.any_emitted) begin
            cmd.flush_none = 1'b1;
            cmd.set_last   = 1'b1;
            state_nxt      = ST_OUT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (st.is_flush && st.any_emitted && !st.scan_end && st.more_dirty) begin
            cmd.scan_step = 1'b1;
            state_nxt     = ST_FLUSH;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- sv/scp_dp.sv -----
// Directory datapath: tags, state bits, clock hand and result word.
module scp_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [1:0]                     in_kind,
  input  logic [scp_pkg::SectorBits-1:0] in_sector,
  input  scp_pkg::cmd_t                  cmd,
  output scp_pkg::stat_t                 st,
  output logic                           out_hit,
  output logic [scp_pkg::SlotBits-1:0]   out_slot,
  output logic                           out_fetch_from_disk,
  output logic                           out_writeback,
  output logic [scp_pkg::SectorBits-1:0] out_writeback_sector,
  output logic                           out_last
);
  import scp_pkg::*;

  sector_t              tag_r [Entries];
  logic [Entries-1:0]   valid_r, used_r, dirty_r;
  slot_t                hand_r, scan_r, free_r;
  logic                 free_found_r, emitted_r;
  logic [CountBits-1:0] count_r;
  logic [WalkBits-1:0]  walk_r;
  kind_t                kind_r;
  sector_t              sec_r;
  logic                 hit_r, fetch_r, wb_r, last_r;
  slot_t                slot_r;
  sector_t              wbsec_r;
  slot_t                victim;
  logic [Entries-1:0]   above;

  assign victim = free_r;

  // Dirty valid slots strictly above the scan index
  always_comb begin
    for (int i = 0; i < Entries; i++)
      above[i] = (slot_t'(i) > scan_r) && valid_r[i] && dirty_r[i];
  end

  assign st.is_flush    = (kind_r == KIND_FLUSH);
  assign st.match       = valid_r[scan_r] && (tag_r[scan_r] == sec_r);
  assign st.scan_end    = (scan_r == slot_t'(Entries - 1));
  assign st.full        = (count_r >= CountBits'(Entries));
  assign st.hand_used   = used_r[hand_r];
  assign st.walk_limit  = (walk_r == WalkBits'(2 * Entries));
  assign st.scan_dirty  = valid_r[scan_r] && dirty_r[scan_r];
  assign st.more_dirty  = |above;
  assign st.any_emitted = emitted_r;

  // Control-side registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      used_r    <= '0;
      dirty_r   <= '0;
      hand_r    <= '0;
      count_r   <= '0;
      scan_r    <= '0;
      free_r    <= '0;
      free_found_r <= 1'b0;
      emitted_r <= 1'b0;
      walk_r    <= '0;
      kind_r    <= KIND_READ;
    end else begin
      if (cmd.load) begin
        kind_r       <= kind_t'(in_kind);
        free_found_r <= 1'b0;
        free_r       <= '0;
        emitted_r    <= 1'b0;
        walk_r       <= '0;
      end
      // Track lowest empty slot while scanning
      if ((kind_r != KIND_FLUSH) && !valid_r[scan_r] && !free_found_r && !cmd.load) begin
        free_r       <= scan_r;
        free_found_r <= 1'b1;
      end
      if (cmd.scan_clr) scan_r <= '0;
      if (cmd.scan_step) scan_r <= scan_r + slot_t'(1);
      if (cmd.hit_emit) begin
        if (kind_r != KIND_PREFETCH) used_r[scan_r] <= 1'b1;
        if (kind_r == KIND_WRITE)    dirty_r[scan_r] <= 1'b1;
      end
      if (cmd.walk_step) begin
        used_r[hand_r] <= 1'b0;
        hand_r <= (hand_r == slot_t'(Entries - 1)) ? '0 : hand_r + slot_t'(1);
        walk_r <= walk_r + WalkBits'(1);
      end
      if (cmd.alloc) begin
        valid_r[st.full ? hand_r : victim] <= 1'b1;
        used_r [st.full ? hand_r : victim] <= (kind_r != KIND_PREFETCH);
        dirty_r[st.full ? hand_r : victim] <= (kind_r == KIND_WRITE);
        if (st.full)
          hand_r <= (hand_r == slot_t'(Entries - 1)) ? '0 : hand_r + slot_t'(1);
        else
          count_r <= count_r + CountBits'(1);
      end
      if (cmd.flush_emit) begin
        dirty_r[scan_r] <= 1'b0;
        emitted_r       <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) sec_r <= in_sector;
    if (cmd.alloc) tag_r[st.full ? hand_r : victim] <= sec_r;
    if (cmd.hit_emit) begin
      hit_r <= 1'b1; slot_r <= scan_r; fetch_r <= 1'b0;
      wb_r <= 1'b0;  wbsec_r <= '0;
    end
    if (cmd.alloc) begin
      hit_r   <= 1'b0;
      slot_r  <= st.full ? hand_r : victim;
      fetch_r <= (kind_r != KIND_WRITE);
      wb_r    <= st.full && dirty_r[hand_r];
      wbsec_r <= (st.full && dirty_r[hand_r]) ? tag_r[hand_r] : '0;
    end
    if (cmd.flush_emit) begin
      hit_r <= 1'b0; slot_r <= scan_r; fetch_r <= 1'b0;
      wb_r <= 1'b1;  wbsec_r <= tag_r[scan_r];
    end
    if (cmd.flush_none) begin
      hit_r <= 1'b0; slot_r <= '0; fetch_r <= 1'b0;
      wb_r <= 1'b0;  wbsec_r <= '0;
    end
    if (cmd.hit_emit || cmd.alloc || cmd.flush_emit || cmd.flush_none)
      last_r <= cmd.set_last;
  end

  assign out_hit              = hit_r;
  assign out_slot             = slot_r;
  assign out_fetch_from_disk  = fetch_r;
  assign out_writeback        = wb_r;
  assign out_writeback_sector = wbsec_r;
  assign out_last             = last_r;

endmodule

// ----- sv/sector_cache_clock_policy.sv -----
// Sector cache directory with clock replacement: top level.
// A request is accepted in the idle state and slots are scanned in turn for a hit.
// On a miss with the cache full, the clock hand walks, clearing used bits, until
// it finds an unused slot (at most one full pass clears used bits); the slot is then
// allocated and one result word delivered. A flush delivers one word per dirty entry,
// or a single empty word if none is dirty. The sequential tag scan sets the rate.
module sector_cache_clock_policy (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_kind,
  input  logic [scp_pkg::SectorBits-1:0] in_sector,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_hit,
  output logic [scp_pkg::SlotBits-1:0]   out_slot,
  output logic                           out_fetch_from_disk,
  output logic                           out_writeback,
  output logic [scp_pkg::SectorBits-1:0] out_writeback_sector,
  output logic                           out_last
);
  import scp_pkg::*;

  cmd_t  cmd;
  stat_t st;

  scp_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .st, .cmd
  );

  scp_dp u_dp (
    .clk, .rst_n, .in_kind, .in_sector, .cmd, .st, .out_hit, .out_slot,
    .out_fetch_from_disk, .out_writeback, .out_writeback_sector, .out_last
  );

endmodule

// ----- sv/scp_checker.sv -----
// Port-level checker for the sector cache directory, bound to the top level.
module scp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_hit,
  input logic       out_fetch_from_disk,
  input logic       out_writeback,
  input logic       out_last
);
  // A word is never offered while a new request is taken
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready and valid together");
  // Hit words carry no fetch and no writeback
  a_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_fetch_from_disk && !out_writeback)
    else $error("hit with side flags");
  // Accepting a request leaves no word pending next cycle
  a_acc: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid) else $error("word too early");
  // Stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_last))
    else $error("word dropped");
endmodule

bind sector_cache_clock_policy scp_checker u_scp_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_hit,
  .out_fetch_from_disk, .out_writeback, .out_last
);

// ----- sim/sector_cache_clock_policy_tb.sv -----
// Testbench for the sector cache directory: predicts results and checks every word.
`timescale 1ns / 100ps

module sector_cache_clock_policy_tb;
  import scp_pkg::*;

  typedef struct packed {
    logic [1:0] kind;
    sector_t    sector;
  } request_t;

  typedef struct packed {
    logic    hit;
    slot_t   slot;
    logic    fetch;
    logic    wb;
    sector_t wb_sector;
    logic    last;
  } word_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_kind;
  sector_t in_sector;
  logic out_valid;
  logic out_ready;
  logic out_hit;
  slot_t out_slot;
  logic out_fetch_from_disk;
  logic out_writeback;
  sector_t out_writeback_sector;
  logic out_last;

  sector_cache_clock_policy u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (in_kind),
    .in_sector           (in_sector),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_hit             (out_hit),
    .out_slot            (out_slot),
    .out_fetch_from_disk (out_fetch_from_disk),
    .out_writeback       (out_writeback),
    .out_writeback_sector(out_writeback_sector),
    .out_last            (out_last)
  );

  // Directory copy
  sector_t dir_tag   [Entries];
  logic    dir_valid [Entries];
  logic    dir_used  [Entries];
  logic    dir_dirty [Entries];
  int      dir_hand;
  int      dir_count;

  request_t pending_reqs[$];
  word_t    expected_words[$];
  int       mismatches = 0;
  int       sender_idle_pct;
  int       receiver_stall_pct;
  int       cycle_count = 0;
  int       hot_sectors[$];

  // Work out the result words for one accepted request
  task automatic predict_request(request_t r);
    word_t w;
    int slot;
    w = '0;
    if (kind_t'(r.kind) == KIND_FLUSH) begin
      slot = -1;
      for (int i = 0; i < Entries; i++) begin
        if (dir_valid[i] && dir_dirty[i]) begin
          w = '0;
          w.slot = slot_t'(i);
          w.wb = 1'b1;
          w.wb_sector = dir_tag[i];
          dir_dirty[i] = 1'b0;
          expected_words.push_back(w);
          slot = i;
        end
      end
      if (slot < 0) begin
        w = '0;
        w.last = 1'b1;
        expected_words.push_back(w);
      end else begin
        expected_words[$].last = 1'b1;
      end
      return;
    end
    slot = -1;
    for (int i = 0; i < Entries; i++) begin
      if (slot < 0 && dir_valid[i] && dir_tag[i] == r.sector) slot = i;
    end
    if (slot >= 0) begin
      if (kind_t'(r.kind) != KIND_PREFETCH) dir_used[slot] = 1'b1;
      if (kind_t'(r.kind) == KIND_WRITE) dir_dirty[slot] = 1'b1;
      w.hit = 1'b1;
      w.slot = slot_t'(slot);
      w.last = 1'b1;
      expected_words.push_back(w);
      return;
    end
    if (dir_count >= Entries) begin
      // Walk the hand, clearing used bits, until an unused slot turns up
      slot = dir_hand;
      for (int n = 0; n < 2 * Entries; n++) begin
        if (!dir_used[slot]) break;
        dir_used[slot] = 1'b0;
        slot = (slot + 1) % Entries;
      end
      dir_hand = (slot + 1) % Entries;
      if (dir_dirty[slot]) begin
        w.wb = 1'b1;
        w.wb_sector = dir_tag[slot];
      end
    end else begin
      for (int i = Entries - 1; i >= 0; i--) begin
        if (!dir_valid[i]) slot = i;
      end
      dir_count++;
    end
    dir_tag[slot] = r.sector;
    dir_valid[slot] = 1'b1;
    dir_used[slot] = kind_t'(r.kind) != KIND_PREFETCH;
    dir_dirty[slot] = kind_t'(r.kind) == KIND_WRITE;
    w.slot = slot_t'(slot);
    w.fetch = kind_t'(r.kind) != KIND_WRITE;
    w.last = 1'b1;
    expected_words.push_back(w);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Driver: present queued requests, idle at random
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_kind <= '0;
      in_sector <= '0;
    end else begin
      if (in_valid && in_ready) begin
        predict_request(pending_reqs.pop_front());
      end
      if ((!in_valid || in_ready) && pending_reqs.size() > 0 &&
          !(in_valid && in_ready && pending_reqs.size() == 0) &&
          $urandom_range(99) >= sender_idle_pct) begin
        in_valid <= 1'b1;
        in_kind <= pending_reqs[0].kind;
        in_sector <= pending_reqs[0].sector;
      end else if (!in_valid || in_ready) begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    word_t got;
    word_t exp_w;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(99) >= receiver_stall_pct;
      if (out_valid && out_ready) begin
        got = {out_hit, out_slot, out_fetch_from_disk, out_writeback,
               out_writeback_sector, out_last};
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %h", got);
        end else begin
          exp_w = expected_words.pop_front();
          if (got !== exp_w) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected hit=%0d slot=%0d fetch=%0d wb=%0d wbsec=%h last=%0d,",
                       exp_w.hit, exp_w.slot, exp_w.fetch, exp_w.wb, exp_w.wb_sector,
                       exp_w.last,
                       " got hit=%0d slot=%0d fetch=%0d wb=%0d wbsec=%h last=%0d",
                       got.hit, got.slot, got.fetch, got.wb,
                       got.wb_sector, got.last);
          end
        end
      end
    end
  end

  // Timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 600000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic request_t make_req(kind_t k, int s);
    request_t r;
    r.kind = k;
    r.sector = sector_t'(s);
    return r;
  endfunction

  // Random request biased toward a working set a bit larger than the cache
  function automatic request_t random_req();
    int pick;
    int s;
    pick = $urandom_range(99);
    if (pick < 4) return make_req(KIND_FLUSH, $urandom);
    s = ($urandom_range(99) < 80) ? hot_sectors[$urandom_range(hot_sectors.size() - 1)]
                                  : $urandom_range(65535);
    if (pick < 45) return make_req(KIND_READ, s);
    if (pick < 80) return make_req(KIND_WRITE, s);
    return make_req(KIND_PREFETCH, s);
  endfunction

  task automatic run_phase(int idle_pct, int stall_pct, int count);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) pending_reqs.push_back(random_req());
    while (pending_reqs.size() > 0 || in_valid || expected_words.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    for (int i = 0; i < Entries; i++) begin
      dir_tag[i] = '0;
      dir_valid[i] = 1'b0;
      dir_used[i] = 1'b0;
      dir_dirty[i] = 1'b0;
    end
    dir_hand = 0;
    dir_count = 0;
    for (int i = 0; i < 40; i++) hot_sectors.push_back($urandom_range(65535));
    hot_sectors.push_back(0);
    hot_sectors.push_back(65535);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty flush, sector extremes, every kind, hits, prefetch hit
    pending_reqs.push_back(make_req(KIND_FLUSH, 0));
    pending_reqs.push_back(make_req(KIND_READ, 0));
    pending_reqs.push_back(make_req(KIND_WRITE, 65535));
    pending_reqs.push_back(make_req(KIND_PREFETCH, 16'h5555));
    pending_reqs.push_back(make_req(KIND_PREFETCH, 16'h5555));
    pending_reqs.push_back(make_req(KIND_READ, 0));
    pending_reqs.push_back(make_req(KIND_WRITE, 0));
    pending_reqs.push_back(make_req(KIND_PREFETCH, 65535));
    pending_reqs.push_back(make_req(KIND_FLUSH, 16'hffff));
    pending_reqs.push_back(make_req(KIND_FLUSH, 0));
    pending_reqs.push_back(make_req(KIND_WRITE, 16'haaaa));
    while (pending_reqs.size() > 0 || in_valid || expected_words.size() > 0)
      @(posedge clk);

    // Random phases, with idle and stall mixes
    run_phase(0, 0, 90);
    run_phase(64, 0, 90);
    run_phase(0, 64, 90);
    run_phase(35, 35, 90);

    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
